/* src/grid_diffusion_sweep_unit_assert.svh */
// Assertion macros for the grid diffusion sweep unit.
// Depends on nothing; included by modules that carry assertions.
`ifndef GRID_DIFFUSION_SWEEP_UNIT_ASSERT_SVH
`define GRID_DIFFUSION_SWEEP_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gds check failed");
// Next-cycle implication checked outside reset.
`define GDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gds check failed");
`endif

/* src/gds_pkg.sv */
// Shared types and constants of the grid diffusion sweep unit.
// Depends on nothing.
package gds_pkg;
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_RATE   = 2'd3;

    // widest cell address: three 5-bit coordinates
    localparam int ADDR_W = 15;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CLR      = 4'd1;  // write zero at address
    localparam logic [3:0] OP_RD       = 4'd2;  // issue read at address
    localparam logic [3:0] OP_ADDAMT   = 4'd3;  // write sat(rdata + amount)
    localparam logic [3:0] OP_CAPV     = 4'd4;  // capture center value
    localparam logic [3:0] OP_MUL      = 4'd5;  // kept = v*ret >> 16
    localparam logic [3:0] OP_WRKEPT   = 4'd6;  // write kept, latch v - kept
    localparam logic [3:0] OP_ADDSHARE = 4'd7;  // write sat(rdata + share)
    localparam logic [3:0] OP_DIVSTEP  = 4'd8;  // one restoring divide step
    localparam logic [3:0] OP_DIVINIT  = 4'd9;  // set up retention divide
    localparam logic [3:0] OP_SHSTEP   = 4'd10; // share = (v - kept) / 6 by reciprocal
    localparam logic [3:0] OP_CAPRES   = 4'd11; // capture read result

    typedef struct packed {
        logic [3:0]        op;
        logic [ADDR_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;
endpackage

/* src/gds_datapath.sv */
// Datapath: cell memory, saturating adders, retention divider, divide by six.
// Depends on gds_pkg.
module gds_datapath #(
    parameter int AW = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gds_pkg::t_dp_cmd    i_cmd,
    input  logic [31:0]         i_amount,
    input  logic [15:0]         i_time_step,
    input  logic [15:0]         i_rate,
    output gds_pkg::t_dp_status o_status,
    output logic [31:0]         o_result
);
    logic [31:0] r_mem [0:(1<<AW)-1];
    logic [31:0] r_rdata;
    logic [31:0] r_v;
    logic [16:0] r_ret;       // up to 65536
    logic [31:0] r_kept;
    logic [31:0] r_share;
    logic [31:0] r_rem;       // share dividend v - kept
    logic [36:0] r_dquo;      // retention quotient/dividend shift reg
    logic [32:0] r_drem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic [31:0] r_result;
    logic [48:0] prod;
    logic [32:0] sum_amt;
    logic [32:0] sum_sh;
    logic [33:0] trial;
    logic [63:0] sh_prod;
    logic        wr_en;
    logic [31:0] wr_data;

    assign prod    = r_v * r_ret;
    assign sum_amt = {1'b0, r_rdata} + {1'b0, i_amount};
    assign sum_sh  = {1'b0, r_rdata} + {1'b0, r_share};
    assign trial   = {r_drem, r_dquo[36]};
    // floor(n / 6) = (n * ceil(2^34 / 6)) >> 34 for any 32-bit n
    assign sh_prod = r_rem * 32'hAAAA_AAAB;

    always_comb begin
        wr_en = 1'b0;
        wr_data = '0;
        unique case (i_cmd.op)
            gds_pkg::OP_CLR: begin
                wr_en = 1'b1;
            end
            gds_pkg::OP_ADDAMT: begin
                wr_en = 1'b1;
                wr_data = sum_amt[32] ? 32'hFFFF_FFFF : sum_amt[31:0];
            end
            gds_pkg::OP_WRKEPT: begin
                wr_en = 1'b1;
                wr_data = r_kept;
            end
            gds_pkg::OP_ADDSHARE: begin
                wr_en = 1'b1;
                wr_data = sum_sh[32] ? 32'hFFFF_FFFF : sum_sh[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_cmd.addr[AW-1:0]] <= wr_data;
        end
        r_rdata <= r_mem[i_cmd.addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.op)
                gds_pkg::OP_DIVINIT: begin
                    r_den  <= {1'b0, 32'(i_time_step * i_rate)} + 33'h10_0000;
                    r_dquo <= 37'h10_0000_0000;
                    r_drem <= '0;
                    r_cnt  <= 6'd37;
                end
                gds_pkg::OP_DIVSTEP: begin
                    if (r_cnt != 6'd0) begin
                        r_cnt <= r_cnt - 6'd1;
                        if (trial >= {1'b0, r_den}) begin
                            r_drem <= 33'(trial - {1'b0, r_den});
                            r_dquo <= {r_dquo[35:0], 1'b1};
                        end else begin
                            r_drem <= trial[32:0];
                            r_dquo <= {r_dquo[35:0], 1'b0};
                        end
                    end else begin
                        r_ret <= r_dquo[16:0];
                    end
                end
                gds_pkg::OP_CAPV: begin
                    r_v <= r_rdata;
                end
                gds_pkg::OP_MUL: begin
                    r_kept <= prod[47:16];
                end
                gds_pkg::OP_WRKEPT: begin
                    r_rem <= r_v - r_kept;
                end
                gds_pkg::OP_SHSTEP: begin
                    r_share <= {2'b00, sh_prod[63:34]};
                end
                gds_pkg::OP_CAPRES: begin
                    r_result <= r_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.div_done = (r_cnt == 6'd0);
    assign o_result = r_result;
endmodule

/* src/gds_controller.sv */
// Controller: sequences clearing, requests and the diffusion sweep.
// Depends on gds_pkg and the assertion header.
`include "grid_diffusion_sweep_unit_assert.svh"
module gds_controller #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16,
    parameter int XW = 4,
    parameter int YW = 4,
    parameter int ZW = 4,
    parameter int AW = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_req_type,
    input  logic [4:0]          i_cell_x,
    input  logic [4:0]          i_cell_y,
    input  logic [4:0]          i_cell_z,
    input  logic [4:0]          i_size_x,
    input  logic [4:0]          i_size_y,
    input  logic [4:0]          i_size_z,
    input  gds_pkg::t_dp_status i_status,
    output gds_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_in_grid,
    output logic                o_use_result
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ARD    = 4'd2;
    localparam logic [3:0] S_AWAIT  = 4'd3;
    localparam logic [3:0] S_AWR    = 4'd4;
    localparam logic [3:0] S_ACAP   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_CRD    = 4'd7;
    localparam logic [3:0] S_CCAP   = 4'd8;
    localparam logic [3:0] S_CMUL   = 4'd9;
    localparam logic [3:0] S_CWR    = 4'd10;
    localparam logic [3:0] S_SHDIV  = 4'd11;
    localparam logic [3:0] S_NRD    = 4'd12;
    localparam logic [3:0] S_NWR    = 4'd13;
    localparam logic [3:0] S_NEXT   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam int CW = XW + YW + ZW;
    localparam int PW = gds_pkg::ADDR_W;

    logic [3:0]    r_state, n_state;
    logic [AW:0]   r_clr;
    logic [4:0]    r_x, r_y, r_z;
    logic [1:0]    r_req;
    logic          r_in;
    logic [2:0]    r_nb;
    logic [4:0]    lim_x, lim_y, lim_z;
    logic          in_req;
    logic [5:0]    nx, ny, nz;
    logic          nb_in;
    logic [AW-1:0] cur_addr, nb_addr;

    assign lim_x = ({1'b0, i_size_x} > 6'(MAX_X)) ? 5'(MAX_X) : i_size_x;
    assign lim_y = ({1'b0, i_size_y} > 6'(MAX_Y)) ? 5'(MAX_Y) : i_size_y;
    assign lim_z = ({1'b0, i_size_z} > 6'(MAX_Z)) ? 5'(MAX_Z) : i_size_z;
    assign in_req = (i_cell_x < lim_x) && (i_cell_y < lim_y) && (i_cell_z < lim_z);

    // neighbour coordinates: order z+1, z-1, y+1, y-1, x+1, x-1
    always_comb begin
        nx = {1'b0, r_x};
        ny = {1'b0, r_y};
        nz = {1'b0, r_z};
        unique case (r_nb)
            3'd0: nz = {1'b0, r_z} + 6'd1;
            3'd1: nz = {1'b0, r_z} - 6'd1;
            3'd2: ny = {1'b0, r_y} + 6'd1;
            3'd3: ny = {1'b0, r_y} - 6'd1;
            3'd4: nx = {1'b0, r_x} + 6'd1;
            default: nx = {1'b0, r_x} - 6'd1;
        endcase
    end
    // underflow wraps to 63, caught by the limit compare
    assign nb_in = (nx < {1'b0, lim_x}) && (ny < {1'b0, lim_y}) && (nz < {1'b0, lim_z});
    assign cur_addr = AW'({r_z[ZW-1:0], r_y[YW-1:0], r_x[XW-1:0]});
    assign nb_addr  = AW'({nz[ZW-1:0], ny[YW-1:0], nx[XW-1:0]});

    always_comb begin
        n_state = r_state;
        o_cmd.op = gds_pkg::OP_NONE;
        o_cmd.addr = PW'(cur_addr);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = gds_pkg::OP_CLR;
                o_cmd.addr = PW'(r_clr[AW-1:0]);
                if (r_clr[AW-1:0] == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == gds_pkg::REQ_TICK) begin
                        o_cmd.op = gds_pkg::OP_DIVINIT;
                        n_state = S_DIV;
                    end else if ((i_req_type == gds_pkg::REQ_ADD ||
                                  i_req_type == gds_pkg::REQ_READ) && in_req) begin
                        n_state = S_ARD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ARD: begin
                o_cmd.op = gds_pkg::OP_RD;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                if (r_req == gds_pkg::REQ_ADD) begin
                    o_cmd.op = gds_pkg::OP_ADDAMT;
                    n_state = S_AWR;
                end else begin
                    o_cmd.op = gds_pkg::OP_CAPRES;
                    n_state = S_DONE;
                end
            end
            S_AWR: begin
                o_cmd.op = gds_pkg::OP_RD;
                n_state = S_ACAP;
            end
            S_ACAP: begin
                o_cmd.op = gds_pkg::OP_CAPRES;
                n_state = S_DONE;
            end
            S_DIV: begin
                o_cmd.op = gds_pkg::OP_DIVSTEP;
                if (i_status.div_done) begin
                    n_state = (lim_x == 5'd0 || lim_y == 5'd0 || lim_z == 5'd0) ?
                              S_DONE : S_CRD;
                end
            end
            S_CRD: begin
                o_cmd.op = gds_pkg::OP_RD;
                n_state = S_CCAP;
            end
            S_CCAP: begin
                o_cmd.op = gds_pkg::OP_CAPV;
                n_state = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.op = gds_pkg::OP_MUL;
                n_state = S_CWR;
            end
            S_CWR: begin
                o_cmd.op = gds_pkg::OP_WRKEPT;
                n_state = S_SHDIV;
            end
            S_SHDIV: begin
                o_cmd.op = gds_pkg::OP_SHSTEP;
                n_state = S_NRD;
            end
            S_NRD: begin
                o_cmd.addr = PW'(nb_addr);
                if (nb_in) begin
                    o_cmd.op = gds_pkg::OP_RD;
                    n_state = S_NWR;
                end else begin
                    n_state = (r_nb == 3'd5) ? S_NEXT : S_NRD;
                end
            end
            S_NWR: begin
                o_cmd.addr = PW'(nb_addr);
                o_cmd.op = gds_pkg::OP_ADDSHARE;
                n_state = (r_nb == 3'd5) ? S_NEXT : S_NRD;
            end
            S_NEXT: begin
                n_state = (r_x == 5'd0 && r_y == 5'd0 && r_z == 5'd0) ? S_DONE : S_CRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_nb    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_IDLE && i_start) begin
                r_req <= i_req_type;
                r_in  <= (i_req_type == gds_pkg::REQ_TICK) ||
                         ((i_req_type == gds_pkg::REQ_ADD ||
                           i_req_type == gds_pkg::REQ_READ) && in_req);
                if (i_req_type == gds_pkg::REQ_TICK) begin
                    r_x <= lim_x - 5'd1;
                    r_y <= lim_y - 5'd1;
                    r_z <= lim_z - 5'd1;
                end else begin
                    r_x <= i_cell_x;
                    r_y <= i_cell_y;
                    r_z <= i_cell_z;
                end
            end
            if ((r_state == S_NRD && !nb_in) || r_state == S_NWR) begin
                r_nb <= (r_nb == 3'd5) ? 3'd0 : r_nb + 3'd1;
            end
            if (r_state == S_NEXT) begin
                if (r_x != 5'd0) begin
                    r_x <= r_x - 5'd1;
                end else begin
                    r_x <= lim_x - 5'd1;
                    if (r_y != 5'd0) begin
                        r_y <= r_y - 5'd1;
                    end else begin
                        r_y <= lim_y - 5'd1;
                        r_z <= r_z - 5'd1;
                    end
                end
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_in_grid = r_in;
    assign o_use_result = (r_req != gds_pkg::REQ_TICK);

    `GDS_ASSERT_NEXT(a_done_one, i_clk, i_rst_n, o_done, !o_done)
    `GDS_ASSERT_IMPL(a_nb_range, i_clk, i_rst_n, r_state == S_NWR, nb_in)
    `GDS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `GDS_ASSERT_IMPL(a_cw_fits, i_clk, i_rst_n, 1'b1, CW <= AW)
endmodule

/* src/grid_diffusion_sweep_unit.sv */
// Top level of the grid diffusion sweep unit: ports, config registers, glue.
// Depends on gds_pkg, gds_controller and gds_datapath.
//
// A 3D grid of Q16.16 densities with add, read and diffusion tick requests.
// After reset the unit clears its cell memory, one cell a cycle, all
// 2^(clog2 MAX_X + clog2 MAX_Y + clog2 MAX_Z) cells (4096 at default);
// busy is high meanwhile. Assert start while busy is low to issue an item;
// the item's fields are taken at that edge and may change afterwards.
// Each item gives exactly one result, on o_done for one cycle; the receiver
// cannot stall it. An add reads the cell, writes the sum and reads it back.
// A tick runs a 37-step retention divide, then visits every cell in use:
// read, multiply, write back, a reciprocal multiply for the sixth, then up
// to six read-modify-write neighbour updates. Write configuration only
// while idle.
module grid_diffusion_sweep_unit #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic [4:0]  i_cell_z,
    input  logic [31:0] i_amount,
    input  logic [15:0] i_time_step,
    output logic        o_done,
    output logic [31:0] o_cell_value,
    output logic        o_in_grid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int AW = XW + YW + ZW;

    logic [4:0]  r_size_x, r_size_y, r_size_z;
    logic [15:0] r_rate;
    logic [31:0] r_amount;
    gds_pkg::t_dp_cmd    cmd;
    gds_pkg::t_dp_status status;
    logic [31:0] result;
    logic        in_grid, use_result;

    assign o_cfg_ready = 1'b1;

    // hold the configuration registers; each of the four indices selects one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 5'd16;
            r_size_y <= 5'd16;
            r_size_z <= 5'd16;
            r_rate   <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gds_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data[4:0];
                gds_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data[4:0];
                gds_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data[4:0];
                default:             r_rate   <= i_cfg_data[15:0];
            endcase
        end
    end

    // hold the add amount from the accepting edge until the write-back
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_amount <= i_amount;
        end
    end

    gds_controller #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
        .XW(XW), .YW(YW), .ZW(ZW), .AW(AW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_req_type(i_req_type), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_z(i_cell_z), .i_size_x(r_size_x), .i_size_y(r_size_y),
        .i_size_z(r_size_z), .i_status(status), .o_cmd(cmd), .o_busy(busy),
        .o_done(o_done), .o_in_grid(in_grid), .o_use_result(use_result)
    );

    gds_datapath #(.AW(AW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_amount(r_amount),
        .i_time_step(i_time_step), .i_rate(r_rate), .o_status(status),
        .o_result(result)
    );

    // zero the value for ticks and for requests outside the grid
    assign o_cell_value = (in_grid && use_result) ? result : 32'd0;
    assign o_in_grid = in_grid;
endmodule
